// ----- sv/block_transfer_sequencer_macros.svh -----
// assertion macros for the block transfer sequencer
`ifndef BLOCK_TRANSFER_SEQUENCER_MACROS_SVH
`define BLOCK_TRANSFER_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define BTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bts check failed: %m");
`define BTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bts check failed: %m");
`else
`define BTS_ASSERT_IMP(lbl, ante, cons)
`define BTS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- sv/bts_pkg.sv -----
package bts_pkg;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  localparam logic [15:0] PC_ONLY_LIST = 16'h8000;
  localparam logic [31:0] WORD_STEP    = 32'd4;
  localparam logic [31:0] EMPTY_STEP   = 32'h0000_0040;
  localparam logic [31:0] ADDR_MASK    = 32'hFFFF_FFFC;
  localparam logic [3:0]  PC_INDEX     = 4'd15;

  typedef struct packed {
    logic [15:0] reg_list;
    logic [3:0]  base_reg;
    logic [31:0] base_value;
    logic        pre_index;
    logic        up;
    logic        load;
    logic        user_bank;
    logic        writeback;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [3:0]  reg_index;
    logic        bank_user;
    logic        sequential;
    logic [31:0] value;
    logic        base_write;
    logic        restore_status;
    logic        branch;
    logic        last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_XFER,
    ST_ADJ,
    ST_REWR,
    ST_DONE
  } state_t;

endpackage

// ----- sv/block_transfer_sequencer.sv -----
// the output register takes an access word for each listed register (an empty
// list counts as one), then a base rewrite word when one is sent, then the
// completion word; a new block transfer is accepted only in idle, once the last
// one is done, and the single address adder steps the address once per access.
// reset: synchronous active-low rst_n returns the sequencer to idle and
// empties the output register
`include "block_transfer_sequencer_macros.svh"

module block_transfer_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bts_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bts_pkg::out_word_t out_data
);
  import bts_pkg::*;

  state_t      state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r, out_data_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [3:0]  rn_r, rn_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] stored_r, stored_nxt;
  logic        p_r, p_nxt;
  logic        u_r, u_nxt;
  logic        l_r, l_nxt;
  logic        bank_r, bank_nxt;
  logic        first_r, first_nxt;
  logic        empty_r, empty_nxt;
  logic        bw_r, bw_nxt;
  logic        rewr_r, rewr_nxt;
  logic        restore_r, restore_nxt;
  logic        branch_r, branch_nxt;

  logic        in_fire;
  logic        slot_free;
  logic [15:0] list_eff;
  logic        empty_in;
  logic        base_listed;
  logic [15:0] lower_mask;
  logic        w_eff;
  logic [3:0]  next_idx;
  logic [15:0] rem_after;
  logic [31:0] add_a;
  logic [31:0] add_amt;
  logic        add_sub;
  logic [31:0] add_sum;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // decode of the incoming word
  assign empty_in    = (in_data.reg_list == 16'd0);
  assign list_eff    = empty_in ? PC_ONLY_LIST : in_data.reg_list;
  assign base_listed = list_eff[in_data.base_reg];
  assign lower_mask  = 16'((16'd1 << in_data.base_reg) - 16'd1);
  assign w_eff       = in_data.writeback && !empty_in && !(in_data.load && base_listed);

  // next register in walk order
  always_comb begin
    next_idx = '0;
    if (u_r) begin
      for (int i = 15; i >= 0; i--) begin
        if (rem_r[i]) next_idx = 4'(i);
      end
    end else begin
      for (int i = 0; i < 16; i++) begin
        if (rem_r[i]) next_idx = 4'(i);
      end
    end
  end

  always_comb begin
    rem_after = rem_r;
    rem_after[next_idx] = 1'b0;
  end

  // shared address adder
  always_comb begin
    add_a   = addr_r;
    add_amt = WORD_STEP;
    add_sub = !u_r;
    case (state_r)
      ST_ADJ: begin
        if (empty_r) begin
          add_a   = base_r;
          add_amt = EMPTY_STEP;
          add_sub = !u_r;
        end else begin
          add_sub = u_r;
        end
      end
      default: begin
        add_a   = addr_r;
        add_amt = WORD_STEP;
        add_sub = !u_r;
      end
    endcase
  end

  assign add_sum = add_sub ? (add_a - add_amt) : (add_a + add_amt);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_PRE;
      ST_PRE:  state_nxt = ST_XFER;
      ST_XFER: if (slot_free && rem_after == 16'd0) state_nxt = ST_ADJ;
      ST_ADJ:  state_nxt = rewr_r ? ST_REWR : ST_DONE;
      ST_REWR: if (slot_free) state_nxt = ST_DONE;
      ST_DONE: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output word
  always_comb begin
    rem_nxt       = rem_r;
    rn_nxt        = rn_r;
    base_nxt      = base_r;
    addr_nxt      = addr_r;
    stored_nxt    = stored_r;
    p_nxt         = p_r;
    u_nxt         = u_r;
    l_nxt         = l_r;
    bank_nxt      = bank_r;
    first_nxt     = first_r;
    empty_nxt     = empty_r;
    bw_nxt        = bw_r;
    rewr_nxt      = rewr_r;
    restore_nxt   = restore_r;
    branch_nxt    = branch_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          rem_nxt     = list_eff;
          rn_nxt      = in_data.base_reg;
          base_nxt    = in_data.base_value;
          addr_nxt    = in_data.base_value;
          p_nxt       = in_data.pre_index;
          u_nxt       = in_data.up;
          l_nxt       = in_data.load;
          bank_nxt    = in_data.user_bank && !(in_data.load && list_eff[PC_INDEX]);
          first_nxt   = 1'b1;
          empty_nxt   = empty_in;
          bw_nxt      = empty_in || w_eff;
          rewr_nxt    = w_eff && !in_data.load && base_listed
                        && ((list_eff & lower_mask) != 16'd0);
          restore_nxt = in_data.user_bank && in_data.load && list_eff[PC_INDEX];
          branch_nxt  = in_data.load && list_eff[PC_INDEX];
        end
      end
      ST_PRE: begin
        if (p_r) addr_nxt = add_sum;
      end
      ST_XFER: begin
        if (slot_free) begin
          rem_nxt   = rem_after;
          addr_nxt  = add_sum;
          first_nxt = 1'b0;
          if (next_idx == rn_r && !l_r) stored_nxt = addr_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.kind       = l_r ? KIND_LOAD : KIND_STORE;
          out_data_nxt.address    = addr_r & ADDR_MASK;
          out_data_nxt.reg_index  = next_idx;
          out_data_nxt.bank_user  = bank_r;
          out_data_nxt.sequential = !first_r;
        end
      end
      ST_ADJ: begin
        if (empty_r || p_r) addr_nxt = add_sum;
      end
      ST_REWR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.kind       = KIND_VALUE;
          out_data_nxt.address    = stored_r & ADDR_MASK;
          out_data_nxt.reg_index  = rn_r;
          out_data_nxt.sequential = 1'b1;
          out_data_nxt.value      = addr_r;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.kind           = KIND_DONE;
          out_data_nxt.reg_index      = rn_r;
          out_data_nxt.value          = bw_r ? addr_r : 32'd0;
          out_data_nxt.base_write     = bw_r;
          out_data_nxt.restore_status = restore_r;
          out_data_nxt.branch         = branch_r;
          out_data_nxt.last           = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    rem_r      <= rem_nxt;
    rn_r       <= rn_nxt;
    base_r     <= base_nxt;
    addr_r     <= addr_nxt;
    stored_r   <= stored_nxt;
    p_r        <= p_nxt;
    u_r        <= u_nxt;
    l_r        <= l_nxt;
    bank_r     <= bank_nxt;
    first_r    <= first_nxt;
    empty_r    <= empty_nxt;
    bw_r       <= bw_nxt;
    rewr_r     <= rewr_nxt;
    restore_r  <= restore_nxt;
    branch_r   <= branch_nxt;
  end

  `BTS_ASSERT_NXT(a_accept_starts, in_fire, state_r == ST_PRE)
  `BTS_ASSERT_IMP(a_xfer_has_work, state_r == ST_XFER, rem_r != 16'd0)
  `BTS_ASSERT_IMP(a_rewrite_store_only, state_r == ST_REWR, !l_r && bw_r)
  `BTS_ASSERT_IMP(a_done_is_last, out_valid_r && out_data_r.kind == KIND_DONE,
                  out_data_r.last)

endmodule
